// ===== rtl/core/frxc_pkg.sv =====
// Shared types and constants for the frame receiver with XOR block check.
// Used by frxc_front, frxc_back and frame_receiver_xor_check; depends on nothing.
`default_nettype none

package frxc_pkg;

  // Default size of one parameter bank, in bytes.
  localparam int unsigned FRXC_PARAM_BYTES = 256;

  // Input opcodes.
  localparam logic [1:0] OP_RX      = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // Reply codes.
  localparam logic [1:0] REPLY_NONE = 2'd0;
  localparam logic [1:0] REPLY_ACK  = 2'd1;
  localparam logic [1:0] REPLY_NAK  = 2'd2;

  // One input beat.
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } frxc_in_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  reply;
    logic        frame_waiting;
    logic [7:0]  frame_dest;
    logic [7:0]  frame_source;
    logic [15:0] frame_sequence;
    logic [7:0]  frame_command;
    logic [7:0]  frame_param_count;
    logic [7:0]  param_data;
  } frxc_out_t;

  // Classified command as it sits in the queue between front and back.
  typedef struct packed {
    logic       is_rx;
    logic       is_read;
    logic       is_release;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } frxc_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/frame_receiver_xor_check.sv =====
// Top level of the frame receiver: queue front end, receive back end, assertions.
// Depends on frxc_pkg, frxc_front and frxc_back.
`default_nettype none

// Frame receiver with XOR block check. Every input beat (a line byte, a read of
// the waiting frame's parameter block, or a release) gives exactly one result
// beat. The block takes one beat per clock while the queue is not full: the
// front end queues up to two decoded commands, and the back end retires one
// per cycle unless the result side stalls, into a result register, with the
// parameter byte read from the store's registered port. in_stall rises only
// while the two-entry queue is full, so a stalled result side still lets two
// more beats in. The parameter store holds two banks of PARAM_BYTES bytes; it
// needs no clearing after reset. local_address is written through the cfg
// port, which is always ready.
module frame_receiver_xor_check import frxc_pkg::*; #(
  parameter int unsigned PARAM_BYTES = FRXC_PARAM_BYTES
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire frxc_in_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output frxc_out_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  logic      cmd_valid;
  logic      cmd_pop;
  frxc_cmd_t cmd;

  assign cfg_ready = 1'b1;

  // Front end: accept and decode.
  frxc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Back end: receive state, parameter store, result register.
  frxc_back #(
    .PARAM_BYTES (PARAM_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The back end never takes a command from an empty queue.
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // An ACK always leaves a frame waiting.
  a_ack_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.reply == REPLY_ACK)) |-> out_data.frame_waiting)
    else $error("ACK without waiting frame");

  // With no frame waiting, all frame fields and read data are zero.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.frame_waiting) |->
      ((out_data.frame_dest == 8'd0) && (out_data.frame_source == 8'd0) &&
       (out_data.frame_sequence == 16'd0) && (out_data.frame_command == 8'd0) &&
       (out_data.frame_param_count == 8'd0) && (out_data.param_data == 8'd0)))
    else $error("frame fields nonzero with no frame waiting");

endmodule

`default_nettype wire

// ===== rtl/core/frxc_front.sv =====
// Front end: accepts input beats, decodes the opcode and queues the command.
// Depends on frxc_pkg.
`default_nettype none

module frxc_front import frxc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire frxc_in_t  in_data,
  output logic           cmd_valid,
  output frxc_cmd_t      cmd,
  input  wire logic      cmd_pop
);

  frxc_cmd_t  q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;
  frxc_cmd_t  dec;

  // The queue is full at two entries; the stall comes straight from a register.
  assign in_stall  = (count_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  // Decode the opcode into one flag per action; the unused code sets none.
  always_comb begin
    dec            = '0;
    dec.rx_byte    = in_data.rx_byte;
    dec.read_index = in_data.read_index;
    unique case (in_data.opcode)
      OP_RX:      dec.is_rx      = 1'b1;
      OP_READ:    dec.is_read    = 1'b1;
      OP_RELEASE: dec.is_release = 1'b1;
      default:    ;
    endcase
  end

  // Occupancy follows push and pop together.
  always_comb begin
    count_nxt = count_r;
    if (push && !cmd_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && cmd_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (cmd_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/frxc_back.sv =====
// Back end: frame receive state machine, parameter store and result register.
// Depends on frxc_pkg.
`default_nettype none

module frxc_back import frxc_pkg::*; #(
  parameter int unsigned PARAM_BYTES = FRXC_PARAM_BYTES
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_we,
  input  wire logic [7:0] cfg_data,
  input  wire logic      cmd_valid,
  input  wire frxc_cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output frxc_out_t      out_data
);

  localparam int unsigned AW = $clog2(2 * PARAM_BYTES);
  localparam logic [8:0]    PB_LIMIT = 9'(PARAM_BYTES);
  localparam logic [AW-1:0] PB_BASE  = AW'(PARAM_BYTES);

  typedef enum logic [6:0] {
    PH_DEST  = 7'b0000001,
    PH_SRC   = 7'b0000010,
    PH_SEQL  = 7'b0000100,
    PH_SEQH  = 7'b0001000,
    PH_CMD   = 7'b0010000,
    PH_PARAM = 7'b0100000,
    PH_CHECK = 7'b1000000
  } frxc_phase_t;

  // Control state.
  frxc_phase_t phase_r, phase_nxt;
  logic        ignore_r, ignore_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic        holding_r, holding_nxt;
  logic        bank_r, bank_nxt;
  logic [7:0]  local_addr_r;
  logic        out_valid_r;

  // Header of the frame being received.
  logic [7:0] hdr_dest_r, hdr_src_r, hdr_seql_r, hdr_seqh_r, hdr_cmd_r;
  logic [7:0] hdr_dest_nxt, hdr_src_nxt, hdr_seql_nxt, hdr_seqh_nxt, hdr_cmd_nxt;

  // Header of the waiting frame.
  logic [7:0]  held_dest_r, held_src_r, held_cmd_r, held_cnt_r;
  logic [15:0] held_seq_r;
  logic [7:0]  held_dest_nxt, held_src_nxt, held_cmd_nxt, held_cnt_nxt;
  logic [15:0] held_seq_nxt;

  // Parameter store, two banks.
  logic [7:0]    param_mem [2 * PARAM_BYTES];
  logic [7:0]    rd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  // Result register.
  frxc_out_t out_r;
  logic      rd_sel_r;
  logic [1:0] reply;

  logic       fire;
  logic [7:0] b;
  logic [7:0] len_eff;
  logic [7:0] cnt_inc;

  assign fire    = cmd_valid && (!out_valid_r || !out_stall);
  assign cmd_pop = fire;
  assign b       = cmd.rx_byte;
  assign cnt_inc = cnt_r + 8'd1;

  // The length byte is the first parameter byte; zero counts as one.
  always_comb begin
    if (cnt_r == 8'd0) begin
      len_eff = (b == 8'd0) ? 8'd1 : b;
    end else begin
      len_eff = len_r;
    end
  end

  // Store addresses: reception fills the bank that is not holding the waiting frame.
  assign wr_addr = bank_r ? AW'(cnt_r) : PB_BASE + AW'(cnt_r);
  assign rd_addr = bank_r ? PB_BASE + AW'(cmd.read_index) : AW'(cmd.read_index);

  // Next state for the command at the head of the queue.
  always_comb begin
    phase_nxt     = phase_r;
    ignore_nxt    = ignore_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    xor_nxt       = xor_r;
    holding_nxt   = holding_r;
    bank_nxt      = bank_r;
    hdr_dest_nxt  = hdr_dest_r;
    hdr_src_nxt   = hdr_src_r;
    hdr_seql_nxt  = hdr_seql_r;
    hdr_seqh_nxt  = hdr_seqh_r;
    hdr_cmd_nxt   = hdr_cmd_r;
    held_dest_nxt = held_dest_r;
    held_src_nxt  = held_src_r;
    held_seq_nxt  = held_seq_r;
    held_cmd_nxt  = held_cmd_r;
    held_cnt_nxt  = held_cnt_r;
    reply         = REPLY_NONE;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    if (fire) begin
      priority if (cmd.is_rx) begin
        xor_nxt = xor_r ^ b;
        unique case (phase_r)
          PH_DEST: begin
            ignore_nxt   = (b != local_addr_r) || holding_r;
            len_nxt      = 8'd0;
            cnt_nxt      = 8'd0;
            xor_nxt      = b;
            hdr_dest_nxt = b;
            phase_nxt    = PH_SRC;
          end
          PH_SRC: begin
            hdr_src_nxt = b;
            phase_nxt   = PH_SEQL;
          end
          PH_SEQL: begin
            hdr_seql_nxt = b;
            phase_nxt    = PH_SEQH;
          end
          PH_SEQH: begin
            hdr_seqh_nxt = b;
            phase_nxt    = PH_CMD;
          end
          PH_CMD: begin
            hdr_cmd_nxt = b;
            phase_nxt   = PH_PARAM;
          end
          PH_PARAM: begin
            len_nxt = len_eff;
            cnt_nxt = cnt_inc;
            wr_en   = ({1'b0, cnt_r} < PB_LIMIT);
            if (cnt_inc == len_eff) begin
              phase_nxt = PH_CHECK;
            end
          end
          PH_CHECK: begin
            if (!ignore_r) begin
              if ((xor_r == b) && !holding_r) begin
                reply         = REPLY_ACK;
                holding_nxt   = 1'b1;
                bank_nxt      = !bank_r;
                held_dest_nxt = hdr_dest_r;
                held_src_nxt  = hdr_src_r;
                held_seq_nxt  = {hdr_seqh_r, hdr_seql_r};
                held_cmd_nxt  = hdr_cmd_r;
                held_cnt_nxt  = len_r;
              end else begin
                reply = REPLY_NAK;
              end
            end
            phase_nxt = PH_DEST;
          end
          default: phase_nxt = PH_DEST;
        endcase
      end else if (cmd.is_read) begin
        rd_en = holding_r && (cmd.read_index < held_cnt_r) &&
                ({1'b0, cmd.read_index} < PB_LIMIT);
      end else if (cmd.is_release) begin
        holding_nxt = 1'b0;
      end else begin
        reply = REPLY_NONE;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_DEST;
      ignore_r     <= 1'b0;
      len_r        <= 8'd0;
      cnt_r        <= 8'd0;
      xor_r        <= 8'd0;
      holding_r    <= 1'b0;
      bank_r       <= 1'b0;
      local_addr_r <= 8'd0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      ignore_r  <= ignore_nxt;
      len_r     <= len_nxt;
      cnt_r     <= cnt_nxt;
      xor_r     <= xor_nxt;
      holding_r <= holding_nxt;
      bank_r    <= bank_nxt;
      if (cfg_we) begin
        local_addr_r <= cfg_data;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Header registers and the result register.
  always_ff @(posedge clk) begin
    hdr_dest_r  <= hdr_dest_nxt;
    hdr_src_r   <= hdr_src_nxt;
    hdr_seql_r  <= hdr_seql_nxt;
    hdr_seqh_r  <= hdr_seqh_nxt;
    hdr_cmd_r   <= hdr_cmd_nxt;
    held_dest_r <= held_dest_nxt;
    held_src_r  <= held_src_nxt;
    held_seq_r  <= held_seq_nxt;
    held_cmd_r  <= held_cmd_nxt;
    held_cnt_r  <= held_cnt_nxt;
    if (fire) begin
      out_r.reply         <= reply;
      out_r.frame_waiting <= holding_nxt;
      out_r.param_data    <= 8'd0;
      rd_sel_r            <= rd_en;
      if (holding_nxt) begin
        out_r.frame_dest        <= held_dest_nxt;
        out_r.frame_source      <= held_src_nxt;
        out_r.frame_sequence    <= held_seq_nxt;
        out_r.frame_command     <= held_cmd_nxt;
        out_r.frame_param_count <= held_cnt_nxt;
      end else begin
        out_r.frame_dest        <= 8'd0;
        out_r.frame_source      <= 8'd0;
        out_r.frame_sequence    <= 16'd0;
        out_r.frame_command     <= 8'd0;
        out_r.frame_param_count <= 8'd0;
      end
    end
  end

  // Parameter store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      param_mem[wr_addr] <= b;
    end
    if (rd_en) begin
      rd_data_r <= param_mem[rd_addr];
    end
  end

  // The read data joins the result register on the way out.
  always_comb begin
    out_data            = out_r;
    out_data.param_data = rd_sel_r ? rd_data_r : 8'd0;
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
